>>> rtl/hpq_pkg.sv
// shared types and codes for the min-heap priority queue
package hpq_pkg;

   localparam int ValueWidth = 32;
   localparam int KeyWidth = 24;
   localparam int OpWidth = 3;
   localparam int StatusWidth = 2;

   localparam logic [OpWidth-1:0] OP_INSERT = 3'd0;
   localparam logic [OpWidth-1:0] OP_APPEND = 3'd1;
   localparam logic [OpWidth-1:0] OP_DEL_VALUE = 3'd2;
   localparam logic [OpWidth-1:0] OP_DEL_KEY = 3'd3;
   localparam logic [OpWidth-1:0] OP_DEL_ROOT = 3'd4;

   localparam logic [StatusWidth-1:0] ST_OK = 2'd0;
   localparam logic [StatusWidth-1:0] ST_FULL = 2'd1;
   localparam logic [StatusWidth-1:0] ST_EMPTY = 2'd2;
   localparam logic [StatusWidth-1:0] ST_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic signed [ValueWidth-1:0] value;
      logic [KeyWidth-1:0]          key;
   } entry_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_SCAN,
      S_SCAN_CHK,
      S_REM_RD,
      S_REM_WR,
      S_RB_NEXT,
      S_SD_CUR,
      S_SD_CHK,
      S_SD_L,
      S_SD_R,
      S_SD_DEC,
      S_ROOT,
      S_ROOT_WAIT
   } state_type;

endpackage

>>> rtl/hpq_mem.sv
// entry store: one write port, one registered read port
module hpq_mem #(
   parameter int CAPACITY = 64
) (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic [$clog2(CAPACITY)-1:0]     wr_addr,
   input  hpq_pkg::entry_type              wr_data,
   input  logic [$clog2(CAPACITY)-1:0]     rd_addr,
   output hpq_pkg::entry_type              rd_data
);
   import hpq_pkg::*;

   entry_type mem [CAPACITY];
   entry_type rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   assign rd_data = rd_ff;

endmodule

>>> rtl/hpq_cmp.sv
// shared compare unit: signed less-than and search match
module hpq_cmp (
   input  hpq_pkg::entry_type               lhs,
   input  hpq_pkg::entry_type               rhs,
   input  logic signed [hpq_pkg::ValueWidth-1:0] find_value,
   input  logic [hpq_pkg::KeyWidth-1:0]     find_key,
   input  logic                             by_key,
   output logic                             less,
   output logic                             match
);
   import hpq_pkg::*;

   assign less = lhs.value < rhs.value;
   assign match = by_key ? (lhs.key == find_key) : (lhs.value == find_value);

endmodule

>>> rtl/min_heap_priority_queue.sv
// min-heap priority queue: sequencer, shared compare unit and entry store
// an append, unused op or rejected op goes straight to the root fetch; a search
// scans entries one by one, a removal moves the last entry into the hole, and a
// rebuild sifts down each parent in turn, one level after another
// throughput: one item at a time, req_stall high until the result is loaded
// synchronous active-high reset clears control and count; store is not cleared
module min_heap_priority_queue #(
   parameter int CAPACITY = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [hpq_pkg::OpWidth-1:0]        req_op,
   input  logic signed [hpq_pkg::ValueWidth-1:0] req_item_value,
   input  logic [hpq_pkg::KeyWidth-1:0]       req_item_key,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [hpq_pkg::StatusWidth-1:0]    rsp_status,
   output logic [$clog2(CAPACITY+1)-1:0]      rsp_count,
   output logic signed [hpq_pkg::ValueWidth-1:0] rsp_root_value,
   output logic [hpq_pkg::KeyWidth-1:0]       rsp_root_key
);
   import hpq_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   state_type state_ff, state_in;

   // latched request beat
   logic [OpWidth-1:0]           op_ff, op_in;
   logic signed [ValueWidth-1:0] val_ff, val_in;
   logic [KeyWidth-1:0]          key_ff, key_in;

   // heap bookkeeping
   logic [CW-1:0]          count_ff, count_in;
   logic [CW-1:0]          j_ff, j_in;        // rebuild index, one above next sift
   logic [AW-1:0]          idx_ff, idx_in;    // search / removal position
   logic [AW-1:0]          pos_ff, pos_in;    // sift hole position
   logic [AW-1:0]          bidx_ff, bidx_in;
   entry_type              cur_ff, cur_in;    // element being sifted
   entry_type              best_ff, best_in;
   logic [StatusWidth-1:0] status_ff, status_in;

   // result register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [StatusWidth-1:0]       rsp_status_ff, rsp_status_in;
   logic [CW-1:0]                rsp_count_ff, rsp_count_in;
   logic signed [ValueWidth-1:0] rsp_value_ff, rsp_value_in;
   logic [KeyWidth-1:0]          rsp_key_ff, rsp_key_in;

   // memory and compare unit hookup
   logic      wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   entry_type wr_data, rd_data;
   logic      cmp_less, cmp_match;

   // child positions of the hole, one bit wider than count
   logic [CW:0] left_pos, right_pos;
   logic        left_ok, right_ok;
   logic        scan_last;
   logic        load_rsp;
   logic [CW-1:0] count_dec;
   logic [CW-1:0] j_dec;

   assign left_pos  = (CW+1)'({pos_ff, 1'b1});
   assign right_pos = left_pos + (CW+1)'(1);
   assign left_ok   = left_pos < {1'b0, count_ff};
   assign right_ok  = right_pos < {1'b0, count_ff};
   assign scan_last = (CW'(idx_ff) + CW'(1)) == count_ff;
   assign count_dec = count_ff - CW'(1);
   assign j_dec     = j_ff - CW'(1);
   assign load_rsp  = (state_ff == S_ROOT_WAIT) && !(rsp_valid_ff && rsp_stall);

   hpq_mem #(.CAPACITY(CAPACITY)) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // one compare unit serves the search and both child tests
   hpq_cmp u_cmp (
      .lhs        (rd_data),
      .rhs        (best_ff),
      .find_value (val_ff),
      .find_key   (key_ff),
      .by_key     (op_ff == OP_DEL_KEY),
      .less       (cmp_less),
      .match      (cmp_match)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_DECODE;
         end
         S_DECODE: begin
            if (op_ff inside {OP_INSERT, OP_APPEND}) begin
               if (count_ff >= CW'(CAPACITY)) state_in = S_ROOT;
               else if (op_ff == OP_INSERT) state_in = S_RB_NEXT;
               else state_in = S_ROOT;
            end else if (op_ff inside {OP_DEL_VALUE, OP_DEL_KEY, OP_DEL_ROOT}) begin
               if (count_ff == '0) state_in = S_ROOT;
               else if (op_ff == OP_DEL_ROOT) state_in = S_REM_RD;
               else state_in = S_SCAN;
            end else begin
               state_in = S_ROOT;
            end
         end
         S_SCAN:     state_in = S_SCAN_CHK;
         S_SCAN_CHK: begin
            if (cmp_match) state_in = S_REM_RD;
            else if (scan_last) state_in = S_ROOT;
            else state_in = S_SCAN;
         end
         S_REM_RD:   state_in = S_REM_WR;
         S_REM_WR:   state_in = S_RB_NEXT;
         S_RB_NEXT: begin
            if (j_ff == '0) state_in = S_ROOT;
            else state_in = S_SD_CUR;
         end
         S_SD_CUR:   state_in = S_SD_CHK;
         S_SD_CHK: begin
            if (left_ok) state_in = S_SD_L;
            else state_in = S_SD_DEC;
         end
         S_SD_L: begin
            if (right_ok) state_in = S_SD_R;
            else state_in = S_SD_DEC;
         end
         S_SD_R:     state_in = S_SD_DEC;
         S_SD_DEC: begin
            if (bidx_ff == pos_ff) state_in = S_RB_NEXT;
            else state_in = S_SD_CHK;
         end
         S_ROOT:     state_in = S_ROOT_WAIT;
         S_ROOT_WAIT: begin
            if (load_rsp) state_in = S_IDLE;
         end
         default:    state_in = S_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      op_in     = op_ff;
      val_in    = val_ff;
      key_in    = key_ff;
      count_in  = count_ff;
      j_in      = j_ff;
      idx_in    = idx_ff;
      pos_in    = pos_ff;
      bidx_in   = bidx_ff;
      cur_in    = cur_ff;
      best_in   = best_ff;
      status_in = status_ff;
      wr_en     = 1'b0;
      wr_addr   = pos_ff;
      wr_data   = cur_ff;
      rd_addr   = '0;
      req_stall = (state_ff != S_IDLE);
      case (state_ff)
         S_IDLE: begin
            op_in     = req_op;
            val_in    = req_item_value;
            key_in    = req_item_key;
            status_in = ST_OK;
         end
         S_DECODE: begin
            idx_in = '0;
            if (op_ff inside {OP_INSERT, OP_APPEND}) begin
               if (count_ff >= CW'(CAPACITY)) begin
                  status_in = ST_FULL;
               end else begin
                  wr_en         = 1'b1;
                  wr_addr       = count_ff[AW-1:0];
                  wr_data.value = val_ff;
                  wr_data.key   = key_ff;
                  count_in      = count_ff + CW'(1);
                  j_in          = count_in >> 1;
               end
            end else if (op_ff inside {OP_DEL_VALUE, OP_DEL_KEY, OP_DEL_ROOT}) begin
               if (count_ff == '0) status_in = ST_EMPTY;
            end
         end
         S_SCAN: begin
            rd_addr = idx_ff;
         end
         S_SCAN_CHK: begin
            if (!cmp_match) begin
               if (scan_last) status_in = ST_NOT_FOUND;
               else idx_in = idx_ff + AW'(1);
            end
         end
         S_REM_RD: begin
            rd_addr = count_dec[AW-1:0];
         end
         S_REM_WR: begin
            // last entry fills the hole, then the count shrinks
            wr_en    = 1'b1;
            wr_addr  = idx_ff;
            wr_data  = rd_data;
            count_in = count_dec;
            j_in     = count_dec >> 1;
         end
         S_RB_NEXT: begin
            if (j_ff != '0) begin
               j_in    = j_dec;
               pos_in  = j_dec[AW-1:0];
               rd_addr = j_dec[AW-1:0];
            end
         end
         S_SD_CUR: begin
            cur_in = rd_data;
         end
         S_SD_CHK: begin
            best_in = cur_ff;
            bidx_in = pos_ff;
            rd_addr = left_pos[AW-1:0];
         end
         S_SD_L: begin
            if (cmp_less) begin
               best_in = rd_data;
               bidx_in = left_pos[AW-1:0];
            end
            rd_addr = right_pos[AW-1:0];
         end
         S_SD_R: begin
            if (cmp_less) begin
               best_in = rd_data;
               bidx_in = right_pos[AW-1:0];
            end
         end
         S_SD_DEC: begin
            // move the smaller child up, or drop the carried entry into the hole
            wr_en   = 1'b1;
            wr_addr = pos_ff;
            if (bidx_ff == pos_ff) begin
               wr_data = cur_ff;
            end else begin
               wr_data = best_ff;
               pos_in  = bidx_ff;
            end
         end
         S_ROOT: begin
            rd_addr = '0;
         end
         S_ROOT_WAIT: begin
            rd_addr = '0;
         end
         default: begin
         end
      endcase
   end

   // result register, freed as soon as the beat is taken
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_key_in    = rsp_key_ff;
      if (load_rsp) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_ff;
         rsp_count_in  = count_ff;
         rsp_value_in  = (count_ff == '0) ? '0 : rd_data.value;
         rsp_key_in    = (count_ff == '0) ? '0 : rd_data.key;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      val_ff        <= val_in;
      key_ff        <= key_in;
      j_ff          <= j_in;
      idx_ff        <= idx_in;
      pos_ff        <= pos_in;
      bidx_ff       <= bidx_in;
      cur_ff        <= cur_in;
      best_ff       <= best_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_key_ff    <= rsp_key_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_count      = rsp_count_ff;
   assign rsp_root_value = rsp_value_ff;
   assign rsp_root_key   = rsp_key_ff;

`ifndef SYNTHESIS
   // count never passes capacity
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   // a request beat locks out the next one
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while busy");

   // a new result only comes from the root fetch
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == S_ROOT_WAIT))
      else $error("result raised outside root fetch");

   // sift hole stays inside the live heap whenever a sift step writes it
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SD_DEC) |-> (CW'(pos_ff) < count_ff))
      else $error("sift position beyond count");
`endif

endmodule
